### design/fcrr_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the frame capture record ring.
package fcrr_pkg;

   localparam int RING_BYTES = 768;
   localparam int MAX_FRAME  = 255;
   localparam int HDR_BYTES  = 6;
   localparam int PTR_W      = $clog2(RING_BYTES);
   localparam int HDR_IDX_W  = $clog2(HDR_BYTES);
   localparam int CQ_DEPTH   = 2;
   localparam int CQ_AW      = $clog2(CQ_DEPTH);

   localparam logic [HDR_IDX_W-1:0] HDR_LAST = HDR_IDX_W'(HDR_BYTES - 1);

   typedef enum logic [1:0] {
      REQ_START  = 2'd0,
      REQ_BYTE   = 2'd1,
      REQ_READ   = 2'd2,
      REQ_UNUSED = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      RES_HEADER = 2'd0,
      RES_BYTE   = 2'd1,
      RES_DROPS  = 2'd2,
      RES_EMPTY  = 2'd3
   } result_kind_type;

   typedef enum logic [1:0] {
      CMD_ABANDON,
      CMD_START,
      CMD_BYTE,
      CMD_READ
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type         op;
      logic               direction;
      logic [7:0]         length;
      logic signed [15:0] rssi;
      logic signed [7:0]  snr;
      logic [7:0]         data;
   } cmd_type;

   typedef struct packed {
      logic             we;
      logic [PTR_W-1:0] waddr;
      logic [7:0]       wdata;
      logic             re;
      logic [PTR_W-1:0] raddr;
   } ram_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WR_HDR,
      ST_RD_DATA
   } back_state_type;

   function automatic logic [PTR_W-1:0] ring_adv(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(RING_BYTES - 1)) ? '0 : p + 1'b1;
   endfunction

endpackage

### design/fcrr_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests, responses and the control register.
interface fcrr_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic               direction;
   logic [7:0]         frame_length;
   logic signed [15:0] rssi;
   logic signed [7:0]  snr;
   logic [7:0]         data_byte;

   modport source (output valid, kind, direction, frame_length, rssi, snr, data_byte,
                   input ready);
   modport sink (input valid, kind, direction, frame_length, rssi, snr, data_byte,
                 output ready);
endinterface

interface fcrr_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         result_kind;
   logic               out_direction;
   logic [7:0]         out_length;
   logic signed [15:0] out_rssi;
   logic signed [7:0]  out_snr;
   logic [7:0]         out_byte;
   logic               last_byte;
   logic [31:0]        dropped_frames;

   modport source (output valid, result_kind, out_direction, out_length, out_rssi,
                   out_snr, out_byte, last_byte, dropped_frames, input ready);
   modport sink (input valid, result_kind, out_direction, out_length, out_rssi,
                 out_snr, out_byte, last_byte, dropped_frames, output ready);
endinterface

interface fcrr_csr_if;
   logic valid;
   logic ready;
   logic report_drops;

   modport source (output valid, report_drops, input ready);
   modport sink (input valid, report_drops, output ready);
endinterface

### design/fcrr_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module fcrr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 768
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### design/fcrr_front.sv
`timescale 1ns / 1ps
// Request front end: accepts requests and turns them into ring commands.
module fcrr_front import fcrr_pkg::*; (
   fcrr_req_if.sink req_ch,
   input  logic     cq_full,
   output logic     push,
   output cmd_type  push_cmd
);

   logic [7:0] len_clamped;

   assign req_ch.ready = !cq_full;
   assign len_clamped  = (req_ch.frame_length > 8'(MAX_FRAME)) ? 8'(MAX_FRAME)
                                                                : req_ch.frame_length;

   always_comb begin
      push_cmd.op        = CMD_BYTE;
      push_cmd.direction = req_ch.direction;
      push_cmd.length    = len_clamped;
      push_cmd.rssi      = req_ch.rssi;
      push_cmd.snr       = req_ch.snr;
      push_cmd.data      = req_ch.data_byte;
      push               = req_ch.valid && !cq_full;
      unique case (req_kind_type'(req_ch.kind))
         REQ_START: begin
            // zero length only abandons the pending frame
            push_cmd.op = (req_ch.frame_length == 8'd0) ? CMD_ABANDON : CMD_START;
         end
         REQ_BYTE: begin
            push_cmd.op = CMD_BYTE;
         end
         REQ_READ: begin
            push_cmd.op = CMD_READ;
         end
         REQ_UNUSED: begin
            push = 1'b0;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

endmodule

### design/fcrr_cmd_fifo.sv
`timescale 1ns / 1ps
// Short command queue between the request front end and the ring engine.
module fcrr_cmd_fifo import fcrr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head_cmd,
   output logic    full,
   output logic    empty
);

   cmd_type            entry_ff [CQ_DEPTH];
   logic [CQ_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CQ_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CQ_AW:0]     count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == (CQ_AW+1)'(CQ_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == CQ_AW'(CQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == CQ_AW'(CQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### design/fcrr_back.sv
`timescale 1ns / 1ps
// Ring engine: executes commands against the byte ring and drives responses.
module fcrr_back import fcrr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     head_cmd,
   input  logic        cq_empty,
   output logic        pop,
   output ram_ctl_type ram_ctl,
   input  logic [7:0]  ram_rdata,
   fcrr_csr_if.sink    csr_ch,
   fcrr_rsp_if.source  rsp_ch
);

   back_state_type        state_ff, state_in;
   logic [PTR_W-1:0]      head_ff, head_in;
   logic [PTR_W-1:0]      tail_ff, tail_in;
   logic [PTR_W-1:0]      wp_ff, wp_in;
   logic [7:0]            wr_rem_ff, wr_rem_in;
   logic                  discard_ff, discard_in;
   logic [7:0]            rd_rem_ff, rd_rem_in;
   logic [31:0]           drops_ff, drops_in;
   logic                  report_ff;
   logic [HDR_IDX_W-1:0]  idx_ff, idx_in;
   logic                  rd_payload_ff, rd_payload_in;

   // frame start fields, held while the header goes out
   logic                  st_dir_ff, st_dir_in;
   logic [7:0]            st_len_ff, st_len_in;
   logic [15:0]           st_rssi_ff, st_rssi_in;
   logic [7:0]            st_snr_ff, st_snr_in;

   // header bytes gathered during a read
   logic                  hd_dir_ff, hd_dir_in;
   logic [7:0]            hd_len_ff, hd_len_in;
   logic [7:0]            hd_lenhi_ff, hd_lenhi_in;
   logic [7:0]            hd_rssi_lo_ff, hd_rssi_lo_in;
   logic [7:0]            hd_rssi_hi_ff, hd_rssi_hi_in;

   logic                  out_valid_ff, out_valid_in;
   result_kind_type       out_kind_ff, out_kind_in;
   logic                  out_dir_ff, out_dir_in;
   logic [7:0]            out_len_ff, out_len_in;
   logic signed [15:0]    out_rssi_ff, out_rssi_in;
   logic signed [7:0]     out_snr_ff, out_snr_in;
   logic [7:0]            out_byte_ff, out_byte_in;
   logic                  out_last_ff, out_last_in;
   logic [31:0]           out_drops_ff, out_drops_in;

   logic                  out_free;
   logic                  take;
   logic [PTR_W:0]        free_space;
   logic [PTR_W:0]        need_space;
   logic                  start_fits;
   logic [7:0]            rd_len;
   logic [7:0]            wr_rem_dec;

   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign take     = (state_ff == ST_IDLE) && !cq_empty &&
                     ((head_cmd.op != CMD_READ) || out_free);
   assign pop      = take;

   // one byte of the ring always stays empty
   assign free_space = (tail_ff > head_ff)
                     ? (PTR_W+1)'(tail_ff - head_ff - 1'b1)
                     : (PTR_W+1)'(RING_BYTES) + {1'b0, tail_ff} - {1'b0, head_ff} - 1'b1;
   assign need_space = (PTR_W+1)'(HDR_BYTES) + (PTR_W+1)'(head_cmd.length);
   assign start_fits = (free_space >= need_space);
   assign wr_rem_dec = wr_rem_ff - 1'b1;
   assign rd_len     = ((hd_lenhi_ff != 8'd0) || (hd_len_ff > 8'(MAX_FRAME)))
                     ? 8'(MAX_FRAME) : hd_len_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (head_cmd.op == CMD_START && start_fits) begin
                  state_in = ST_WR_HDR;
               end else if (head_cmd.op == CMD_READ &&
                            (rd_rem_ff != 8'd0 || tail_ff != head_ff)) begin
                  state_in = ST_RD_DATA;
               end
            end
         end
         ST_WR_HDR: begin
            if (idx_ff == HDR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_RD_DATA: begin
            if (rd_payload_ff || idx_ff == HDR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      wp_in         = wp_ff;
      wr_rem_in     = wr_rem_ff;
      discard_in    = discard_ff;
      rd_rem_in     = rd_rem_ff;
      drops_in      = drops_ff;
      idx_in        = idx_ff;
      rd_payload_in = rd_payload_ff;
      st_dir_in     = st_dir_ff;
      st_len_in     = st_len_ff;
      st_rssi_in    = st_rssi_ff;
      st_snr_in     = st_snr_ff;
      hd_dir_in     = hd_dir_ff;
      hd_len_in     = hd_len_ff;
      hd_lenhi_in   = hd_lenhi_ff;
      hd_rssi_lo_in = hd_rssi_lo_ff;
      hd_rssi_hi_in = hd_rssi_hi_ff;
      out_valid_in  = out_valid_ff && !rsp_ch.ready;
      out_kind_in   = out_kind_ff;
      out_dir_in    = out_dir_ff;
      out_len_in    = out_len_ff;
      out_rssi_in   = out_rssi_ff;
      out_snr_in    = out_snr_ff;
      out_byte_in   = out_byte_ff;
      out_last_in   = out_last_ff;
      out_drops_in  = out_drops_ff;
      ram_ctl.we    = 1'b0;
      ram_ctl.waddr = wp_ff;
      ram_ctl.wdata = 8'd0;
      ram_ctl.re    = 1'b0;
      ram_ctl.raddr = tail_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               unique case (head_cmd.op)
                  CMD_ABANDON: begin
                     wr_rem_in  = 8'd0;
                     discard_in = 1'b0;
                  end
                  CMD_START: begin
                     wr_rem_in  = head_cmd.length;
                     discard_in = !start_fits;
                     if (!start_fits) begin
                        drops_in = (drops_ff == '1) ? drops_ff : drops_ff + 1'b1;
                     end else begin
                        wp_in      = head_ff;
                        idx_in     = '0;
                        st_dir_in  = head_cmd.direction;
                        st_len_in  = head_cmd.length;
                        st_rssi_in = head_cmd.rssi;
                        st_snr_in  = head_cmd.snr;
                     end
                  end
                  CMD_BYTE: begin
                     if (wr_rem_ff != 8'd0) begin
                        wr_rem_in = wr_rem_dec;
                        if (discard_ff) begin
                           if (wr_rem_dec == 8'd0) begin
                              discard_in = 1'b0;
                           end
                        end else begin
                           ram_ctl.we    = 1'b1;
                           ram_ctl.wdata = head_cmd.data;
                           wp_in         = ring_adv(wp_ff);
                           // last byte commits the record
                           if (wr_rem_dec == 8'd0) begin
                              head_in = ring_adv(wp_ff);
                           end
                        end
                     end
                  end
                  CMD_READ: begin
                     if (rd_rem_ff != 8'd0) begin
                        ram_ctl.re    = 1'b1;
                        tail_in       = ring_adv(tail_ff);
                        rd_rem_in     = rd_rem_ff - 1'b1;
                        rd_payload_in = 1'b1;
                     end else if (tail_ff == head_ff) begin
                        drops_in     = '0;
                        out_valid_in = 1'b1;
                        out_dir_in   = 1'b0;
                        out_len_in   = 8'd0;
                        out_rssi_in  = '0;
                        out_snr_in   = '0;
                        out_byte_in  = 8'd0;
                        out_last_in  = 1'b0;
                        if (report_ff && drops_ff != 32'd0) begin
                           out_kind_in  = RES_DROPS;
                           out_drops_in = drops_ff;
                        end else begin
                           out_kind_in  = RES_EMPTY;
                           out_drops_in = 32'd0;
                        end
                     end else begin
                        ram_ctl.re    = 1'b1;
                        tail_in       = ring_adv(tail_ff);
                        idx_in        = '0;
                        rd_payload_in = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WR_HDR: begin
            ram_ctl.we = 1'b1;
            wp_in      = ring_adv(wp_ff);
            idx_in     = idx_ff + 1'b1;
            unique case (idx_ff)
               3'd0:    ram_ctl.wdata = {7'd0, st_dir_ff};
               3'd1:    ram_ctl.wdata = st_len_ff;
               3'd2:    ram_ctl.wdata = 8'd0;
               3'd3:    ram_ctl.wdata = st_rssi_ff[7:0];
               3'd4:    ram_ctl.wdata = st_rssi_ff[15:8];
               3'd5:    ram_ctl.wdata = st_snr_ff;
               default: ram_ctl.wdata = 8'd0;
            endcase
         end
         ST_RD_DATA: begin
            if (rd_payload_ff) begin
               out_valid_in = 1'b1;
               out_kind_in  = RES_BYTE;
               out_dir_in   = 1'b0;
               out_len_in   = 8'd0;
               out_rssi_in  = '0;
               out_snr_in   = '0;
               out_byte_in  = ram_rdata;
               out_last_in  = (rd_rem_ff == 8'd0);
               out_drops_in = 32'd0;
            end else if (idx_ff == HDR_LAST) begin
               // snr byte arrives now; everything else is already gathered
               out_valid_in = 1'b1;
               out_kind_in  = RES_HEADER;
               out_dir_in   = hd_dir_ff;
               out_len_in   = rd_len;
               out_rssi_in  = $signed({hd_rssi_hi_ff, hd_rssi_lo_ff});
               out_snr_in   = $signed(ram_rdata);
               out_byte_in  = 8'd0;
               out_last_in  = 1'b0;
               out_drops_in = 32'd0;
               rd_rem_in    = rd_len;
            end else begin
               ram_ctl.re = 1'b1;
               tail_in    = ring_adv(tail_ff);
               idx_in     = idx_ff + 1'b1;
               unique case (idx_ff)
                  3'd0:    hd_dir_in     = ram_rdata[0];
                  3'd1:    hd_len_in     = ram_rdata;
                  3'd2:    hd_lenhi_in   = ram_rdata;
                  3'd3:    hd_rssi_lo_in = ram_rdata;
                  3'd4:    hd_rssi_hi_in = ram_rdata;
                  default: hd_dir_in     = hd_dir_ff;
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         wp_ff         <= '0;
         wr_rem_ff     <= '0;
         discard_ff    <= 1'b0;
         rd_rem_ff     <= '0;
         drops_ff      <= '0;
         report_ff     <= 1'b1;
         idx_ff        <= '0;
         rd_payload_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         wp_ff         <= wp_in;
         wr_rem_ff     <= wr_rem_in;
         discard_ff    <= discard_in;
         rd_rem_ff     <= rd_rem_in;
         drops_ff      <= drops_in;
         idx_ff        <= idx_in;
         rd_payload_ff <= rd_payload_in;
         out_valid_ff  <= out_valid_in;
         if (csr_ch.valid) begin
            report_ff <= csr_ch.report_drops;
         end
      end
   end

   always_ff @(posedge clock) begin
      st_dir_ff     <= st_dir_in;
      st_len_ff     <= st_len_in;
      st_rssi_ff    <= st_rssi_in;
      st_snr_ff     <= st_snr_in;
      hd_dir_ff     <= hd_dir_in;
      hd_len_ff     <= hd_len_in;
      hd_lenhi_ff   <= hd_lenhi_in;
      hd_rssi_lo_ff <= hd_rssi_lo_in;
      hd_rssi_hi_ff <= hd_rssi_hi_in;
      out_kind_ff   <= out_kind_in;
      out_dir_ff    <= out_dir_in;
      out_len_ff    <= out_len_in;
      out_rssi_ff   <= out_rssi_in;
      out_snr_ff    <= out_snr_in;
      out_byte_ff   <= out_byte_in;
      out_last_ff   <= out_last_in;
      out_drops_ff  <= out_drops_in;
   end

   assign csr_ch.ready          = 1'b1;
   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.result_kind    = out_kind_ff;
   assign rsp_ch.out_direction  = out_dir_ff;
   assign rsp_ch.out_length     = out_len_ff;
   assign rsp_ch.out_rssi       = out_rssi_ff;
   assign rsp_ch.out_snr        = out_snr_ff;
   assign rsp_ch.out_byte       = out_byte_ff;
   assign rsp_ch.last_byte      = out_last_ff;
   assign rsp_ch.dropped_frames = out_drops_ff;

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, head_ff} < (PTR_W+1)'(RING_BYTES)) &&
      ({1'b0, tail_ff} < (PTR_W+1)'(RING_BYTES)))
      else $error("ring pointer out of range");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == ST_IDLE))
      else $error("command taken while engine busy");

   a_no_write_on_read: assert property (@(posedge clock) disable iff (reset)
      ram_ctl.we |-> (state_ff != ST_RD_DATA) && !ram_ctl.re)
      else $error("ring write during a read sequence");

   a_discard_pending: assert property (@(posedge clock) disable iff (reset)
      discard_ff |-> (wr_rem_ff != 8'd0))
      else $error("discarding with no bytes left");

   a_read_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD_DATA && state_in == ST_IDLE) |=> out_valid_ff)
      else $error("read sequence ended without a response");

endmodule

### design/frame_capture_record_ring.sv
`timescale 1ns / 1ps
// Frame capture record ring: byte ring of variable-length frame records.
// Each request passes through a two-entry command queue into a ring engine built around
// one byte-wide ring memory with a single write and a single registered read port, and
// that one port sets the cost: a frame start checks free space, then writes its header
// (none if the frame is dropped or has zero length); a payload byte is one write; a
// header read fetches its bytes in turn, a payload read waits on the read data, an
// empty read answers directly. Requests are still taken while a response waits, until
// the queue fills. The ring keeps one byte empty; a frame that does not fit is dropped
// and counted; an empty read clears that count, reporting it if report_drops is set.
module frame_capture_record_ring import fcrr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   fcrr_req_if.sink   req_ch,
   fcrr_rsp_if.source rsp_ch,
   fcrr_csr_if.sink   csr_ch
);

   cmd_type     push_cmd;
   cmd_type     head_cmd;
   logic        push;
   logic        pop;
   logic        cq_full;
   logic        cq_empty;
   ram_ctl_type ram_ctl;
   logic [7:0]  ram_rdata;

   fcrr_front u_front (
      .req_ch   (req_ch),
      .cq_full  (cq_full),
      .push     (push),
      .push_cmd (push_cmd)
   );

   fcrr_cmd_fifo u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .full     (cq_full),
      .empty    (cq_empty)
   );

   fcrr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_cmd  (head_cmd),
      .cq_empty  (cq_empty),
      .pop       (pop),
      .ram_ctl   (ram_ctl),
      .ram_rdata (ram_rdata),
      .csr_ch    (csr_ch),
      .rsp_ch    (rsp_ch)
   );

   fcrr_ram #(
      .WIDTH (8),
      .DEPTH (RING_BYTES)
   ) u_ring (
      .clock (clock),
      .we    (ram_ctl.we),
      .waddr (ram_ctl.waddr),
      .wdata (ram_ctl.wdata),
      .re    (ram_ctl.re),
      .raddr (ram_ctl.raddr),
      .rdata (ram_rdata)
   );

endmodule

### tb/sv/tb_frame_capture_record_ring.sv
`timescale 1ns / 1ps
// Self-checking testbench for the frame capture record ring, with a predictor and random traffic.
module tb_frame_capture_record_ring;
   import fcrr_pkg::*;

   localparam int CYCLE_LIMIT  = 250000;
   localparam int QUIET_CYCLES = 32;
   localparam int HOLD_CYCLES  = 400;
   localparam int N_DIRECTED   = 25;
   localparam int N_PHASES     = 5;

   typedef struct packed {
      req_kind_type       kind;
      logic               dir;
      logic [7:0]         len;
      logic signed [15:0] rssi;
      logic signed [7:0]  snr;
      logic [7:0]         data;
   } frame_req_type;

   typedef struct packed {
      result_kind_type    kind;
      logic               dir;
      logic [7:0]         len;
      logic signed [15:0] rssi;
      logic signed [7:0]  snr;
      logic [7:0]         pay;
      logic               last;
      logic [31:0]        drops;
   } ring_rsp_type;

   typedef struct packed {
      frame_req_type rq;
      bit            typed;
      ring_rsp_type  want;
   } stim_row_type;

   typedef struct packed {
      bit        report;
      bit [7:0]  read_pct;
      bit        mixed;
      bit [15:0] budget;
      bit        hold;
      bit        steady;
   } phase_plan_type;

   localparam ring_rsp_type NO_RSP    = '0;
   localparam ring_rsp_type EMPTY_RSP = '{RES_EMPTY, 1'b0, 8'd0, 16'sh0, 8'sh0, 8'h00, 1'b0,
                                          32'd0};

   logic clock = 1'b0;
   logic reset = 1'b1;

   fcrr_req_if req_ch ();
   fcrr_rsp_if rsp_ch ();
   fcrr_csr_if csr_ch ();

   frame_capture_record_ring u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #5 clock = ~clock;

   // directed requests; typed expectations only where they are obvious
   stim_row_type directed_rows [N_DIRECTED] = '{
      '{'{REQ_READ,   1'b0, 8'd0,   16'sh0000, 8'sh00, 8'h00}, 1'b1, EMPTY_RSP},
      '{'{REQ_BYTE,   1'b0, 8'd0,   16'sh0000, 8'sh00, 8'hFF}, 1'b0, NO_RSP},
      '{'{REQ_UNUSED, 1'b1, 8'd9,   16'shFFFF, 8'shFF, 8'hFF}, 1'b0, NO_RSP},
      '{'{REQ_START,  1'b1, 8'd0,   16'shFFFF, 8'shFF, 8'h00}, 1'b0, NO_RSP},
      '{'{REQ_READ,   1'b0, 8'd0,   16'sh0000, 8'sh00, 8'h00}, 1'b1, EMPTY_RSP},
      '{'{REQ_START,  1'b1, 8'd1,   16'sh8000, 8'sh80, 8'h00}, 1'b0, NO_RSP},
      '{'{REQ_BYTE,   1'b0, 8'd0,   16'sh0000, 8'sh00, 8'hFF}, 1'b0, NO_RSP},
      '{'{REQ_READ,   1'b0, 8'd0,   16'sh0000, 8'sh00, 8'h00}, 1'b1,
        '{RES_HEADER, 1'b1, 8'd1, 16'sh8000, 8'sh80, 8'h00, 1'b0, 32'd0}},
      '{'{REQ_READ,   1'b0, 8'd0,   16'sh0000, 8'sh00, 8'h00}, 1'b1,
        '{RES_BYTE, 1'b0, 8'd0, 16'sh0000, 8'sh00, 8'hFF, 1'b1, 32'd0}},
      '{'{REQ_START,  1'b0, 8'd255, 16'sh7FFF, 8'sh7F, 8'h00}, 1'b0, NO_RSP},
      '{'{REQ_BYTE,   1'b0, 8'd0,   16'sh0000, 8'sh00, 8'h00}, 1'b0, NO_RSP},
      '{'{REQ_START,  1'b1, 8'd3,   16'sh1234, 8'sh05, 8'h00}, 1'b0, NO_RSP},
      '{'{REQ_BYTE,   1'b0, 8'd0,   16'sh0000, 8'sh00, 8'hA5}, 1'b0, NO_RSP},
      '{'{REQ_BYTE,   1'b0, 8'd0,   16'sh0000, 8'sh00, 8'h5A}, 1'b0, NO_RSP},
      '{'{REQ_BYTE,   1'b0, 8'd0,   16'sh0000, 8'sh00, 8'h00}, 1'b0, NO_RSP},
      '{'{REQ_READ,   1'b0, 8'd0,   16'sh0000, 8'sh00, 8'h00}, 1'b0, NO_RSP},
      '{'{REQ_READ,   1'b0, 8'd0,   16'sh0000, 8'sh00, 8'h00}, 1'b0, NO_RSP},
      '{'{REQ_READ,   1'b0, 8'd0,   16'sh0000, 8'sh00, 8'h00}, 1'b0, NO_RSP},
      '{'{REQ_READ,   1'b0, 8'd0,   16'sh0000, 8'sh00, 8'h00}, 1'b0, NO_RSP},
      '{'{REQ_READ,   1'b0, 8'd0,   16'sh0000, 8'sh00, 8'h00}, 1'b1, EMPTY_RSP},
      '{'{REQ_START,  1'b0, 8'd2,   16'sh7FFF, 8'sh7F, 8'h00}, 1'b0, NO_RSP},
      '{'{REQ_BYTE,   1'b0, 8'd0,   16'sh0000, 8'sh00, 8'h01}, 1'b0, NO_RSP},
      '{'{REQ_START,  1'b1, 8'd0,   16'sh0000, 8'sh00, 8'h00}, 1'b0, NO_RSP},
      '{'{REQ_BYTE,   1'b0, 8'd0,   16'sh0000, 8'sh00, 8'h02}, 1'b0, NO_RSP},
      '{'{REQ_READ,   1'b0, 8'd0,   16'sh0000, 8'sh00, 8'h00}, 1'b1, EMPTY_RSP}
   };

   // fill with small frames, drain under a receiver hold-off, then mixed traffic
   phase_plan_type phase_plans [N_PHASES] = '{
      '{1'b1, 8'd0,  1'b0, 16'd500, 1'b0, 1'b0},
      '{1'b1, 8'd80, 1'b1, 16'd350, 1'b1, 1'b0},
      '{1'b0, 8'd20, 1'b1, 16'd300, 1'b0, 1'b1},
      '{1'b0, 8'd75, 1'b0, 16'd250, 1'b0, 1'b0},
      '{1'b1, 8'd45, 1'b1, 16'd250, 1'b0, 1'b0}
   };

   // predictor state
   logic [7:0]  mdl_ring [RING_BYTES];
   int unsigned mdl_head, mdl_tail, mdl_wptr, mdl_wr_left, mdl_rd_left;
   bit          mdl_discard;
   logic [31:0] mdl_drops;
   bit          mdl_report;

   ring_rsp_type pending_rsp [$];
   int          mismatches, requests_sent, frames_dropped, holds_done;
   int          rsp_by_kind [4];
   int          cycle_count;
   int          tx_idle_pct, rx_idle_pct;
   int          hold_left;
   bit          hold_request;

   function automatic int unsigned ring_next(input int unsigned p);
      return (p == RING_BYTES - 1) ? 0 : p + 1;
   endfunction

   function automatic void mdl_append(input logic [7:0] b);
      mdl_ring[mdl_wptr] = b;
      mdl_wptr = ring_next(mdl_wptr);
   endfunction

   function automatic bit predict_ring_response(input frame_req_type rq,
                                                output ring_rsp_type rsp);
      int unsigned used, room, hdr_len;
      logic [7:0]  hb [HDR_BYTES];
      rsp = '0;
      case (rq.kind)
         REQ_START: begin
            mdl_wr_left = 0;
            mdl_discard = 1'b0;
            if (rq.len != 0) begin
               mdl_wr_left = rq.len;
               used = (mdl_head >= mdl_tail) ? mdl_head - mdl_tail
                                             : RING_BYTES - mdl_tail + mdl_head;
               room = RING_BYTES - used - 1;
               if (room < HDR_BYTES + rq.len) begin
                  if (mdl_drops != '1) mdl_drops++;
                  frames_dropped++;
                  mdl_discard = 1'b1;
               end else begin
                  mdl_wptr = mdl_head;
                  mdl_append({7'd0, rq.dir});
                  mdl_append(rq.len);
                  mdl_append(8'd0);
                  mdl_append(rq.rssi[7:0]);
                  mdl_append(rq.rssi[15:8]);
                  mdl_append(rq.snr);
               end
            end
            return 1'b0;
         end
         REQ_BYTE: begin
            if (mdl_wr_left == 0) return 1'b0;
            mdl_wr_left--;
            if (mdl_discard) begin
               if (mdl_wr_left == 0) mdl_discard = 1'b0;
               return 1'b0;
            end
            mdl_append(rq.data);
            // the record becomes visible to reads only after its last byte
            if (mdl_wr_left == 0) mdl_head = mdl_wptr;
            return 1'b0;
         end
         REQ_READ: begin
            if (mdl_rd_left != 0) begin
               rsp.kind = RES_BYTE;
               rsp.pay  = mdl_ring[mdl_tail];
               mdl_tail = ring_next(mdl_tail);
               mdl_rd_left--;
               rsp.last = (mdl_rd_left == 0);
            end else if (mdl_tail == mdl_head) begin
               // empty read always clears the count
               if (mdl_report && mdl_drops != 0) begin
                  rsp.kind  = RES_DROPS;
                  rsp.drops = mdl_drops;
               end else begin
                  rsp.kind = RES_EMPTY;
               end
               mdl_drops = '0;
            end else begin
               for (int i = 0; i < HDR_BYTES; i++) begin
                  hb[i] = mdl_ring[mdl_tail];
                  mdl_tail = ring_next(mdl_tail);
               end
               hdr_len = {hb[2], hb[1]};
               if (hdr_len > MAX_FRAME) hdr_len = MAX_FRAME;
               mdl_rd_left = hdr_len;
               rsp.kind = RES_HEADER;
               rsp.dir  = hb[0][0];
               rsp.len  = hdr_len[7:0];
               rsp.rssi = {hb[4], hb[3]};
               rsp.snr  = hb[5];
            end
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic frame_req_type random_request(input req_kind_type k, input int flen);
      frame_req_type r;
      r.kind = k;
      r.dir  = 1'($urandom_range(1));
      r.len  = 8'(flen);
      r.rssi = 16'($urandom);
      r.snr  = 8'($urandom);
      r.data = 8'($urandom);
      return r;
   endfunction

   task automatic offer_request(input frame_req_type rq, input bit typed,
                                input ring_rsp_type typed_want);
      ring_rsp_type want;
      bit           makes;
      @(negedge clock);
      if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.kind         = rq.kind;
      req_ch.direction    = rq.dir;
      req_ch.frame_length = rq.len;
      req_ch.rssi         = rq.rssi;
      req_ch.snr          = rq.snr;
      req_ch.data_byte    = rq.data;
      req_ch.valid        = 1'b1;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      if (rq.kind != REQ_UNUSED && !(rq.kind == REQ_BYTE && mdl_wr_left == 0))
         requests_sent++;
      makes = predict_ring_response(rq, want);
      if (makes) pending_rsp.push_back(typed ? typed_want : want);
   endtask

   task automatic wait_quiet();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      // starts and payload requests still in flight produce no response
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_report_drops(input bit v);
      @(negedge clock);
      csr_ch.report_drops = v;
      csr_ch.valid        = 1'b1;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      mdl_report = v;
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
   endtask

   // response checker
   always @(posedge clock) begin
      ring_rsp_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            $display("%0t: response with nothing expected: expected none, actual kind %0d",
                     $time, rsp_ch.result_kind);
         end else begin
            want = pending_rsp.pop_front();
            rsp_by_kind[want.kind]++;
            compare_field("result_kind",    want.kind,  rsp_ch.result_kind);
            compare_field("out_direction",  want.dir,   rsp_ch.out_direction);
            compare_field("out_length",     want.len,   rsp_ch.out_length);
            compare_field("out_rssi",       want.rssi,  rsp_ch.out_rssi);
            compare_field("out_snr",        want.snr,   rsp_ch.out_snr);
            compare_field("out_byte",       want.pay,   rsp_ch.out_byte);
            compare_field("last_byte",      want.last,  rsp_ch.last_byte);
            compare_field("dropped_frames", want.drops, rsp_ch.dropped_frames);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time, pending_rsp.size());
         $display("Verification failed");
         $finish;
      end
   end

   // response side: random back-pressure plus one long hold-off on demand
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
            holds_done++;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready = 1'b0;
         end else begin
            rsp_ch.ready = (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   initial begin
      phase_plan_type plan;
      int             start_count, pick, flen, n_bytes;
      req_ch.valid        = 1'b0;
      req_ch.kind         = REQ_START;
      req_ch.direction    = 1'b0;
      req_ch.frame_length = '0;
      req_ch.rssi         = '0;
      req_ch.snr          = '0;
      req_ch.data_byte    = '0;
      csr_ch.valid        = 1'b0;
      csr_ch.report_drops = 1'b1;
      mdl_head    = 0;
      mdl_tail    = 0;
      mdl_wptr    = 0;
      mdl_wr_left = 0;
      mdl_rd_left = 0;
      mdl_discard = 1'b0;
      mdl_drops   = '0;
      mdl_report  = 1'b1;
      tx_idle_pct = 15;
      rx_idle_pct = 15;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < N_DIRECTED; i++)
         offer_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].want);

      for (int p = 0; p < N_PHASES; p++) begin
         plan = phase_plans[p];
         wait_quiet();
         write_report_drops(plan.report);
         tx_idle_pct = plan.steady ? 0 : 15;
         rx_idle_pct = plan.steady ? 0 : 15;
         // reads keep coming while the receiver stalls, so the block backs up
         if (plan.hold) hold_request = 1'b1;
         start_count = requests_sent;
         while (requests_sent - start_count < plan.budget) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
               offer_request(random_request($urandom_range(1) ? REQ_UNUSED : REQ_BYTE, 0),
                             1'b0, NO_RSP);
            end else if (pick < 4 + plan.read_pct) begin
               repeat ($urandom_range(1, 16))
                  offer_request(random_request(REQ_READ, 0), 1'b0, NO_RSP);
            end else begin
               pick = $urandom_range(99);
               if (pick < 3)                       flen = 0;
               else if (!plan.mixed || pick < 65)  flen = $urandom_range(1, 8);
               else if (pick < 90)                 flen = $urandom_range(9, 64);
               else                                flen = $urandom_range(128, MAX_FRAME);
               n_bytes = flen;
               // sometimes cut the frame short so the next start abandons it
               if (flen != 0 && $urandom_range(99) < 8) n_bytes = $urandom_range(0, flen - 1);
               offer_request(random_request(REQ_START, flen), 1'b0, NO_RSP);
               for (int b = 0; b < n_bytes; b++) begin
                  if ($urandom_range(99) < 4)
                     offer_request(random_request(REQ_READ, 0), 1'b0, NO_RSP);
                  offer_request(random_request(REQ_BYTE, 0), 1'b0, NO_RSP);
               end
            end
         end
      end

      wait_quiet();
      $display("Run covered %0d requests over %0d phases, %0d frames dropped, %0d hold-offs.",
               requests_sent, N_PHASES, frames_dropped, holds_done);
      $display("Checked %0d headers, %0d payload bytes, %0d drop reports, %0d empty reads.",
               rsp_by_kind[RES_HEADER], rsp_by_kind[RES_BYTE], rsp_by_kind[RES_DROPS],
               rsp_by_kind[RES_EMPTY]);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
